>>> rtl/core/fq_pkg.sv
// shared constants, types and codes for the searchable fifo queue
`default_nettype none
package fq_pkg;
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 5;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef logic [DATA_WIDTH-1:0] data_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic  push;
        logic  pop;
        data_t data;
    } cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/fq_req_if.sv
// request channel: operation and value
`default_nettype none
interface fq_req_if;
    logic                            valid;
    logic                            ready;
    logic [fq_pkg::OP_W-1:0]         operation;
    logic signed [fq_pkg::WORD_W-1:0] value;

    modport source (output valid, operation, value, input ready);
    modport sink (input valid, operation, value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fq_rsp_if.sv
// response channel: result of one operation
`default_nettype none
interface fq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [fq_pkg::WORD_W-1:0] popped_value;
    logic signed [fq_pkg::WORD_W-1:0] front_value;
    logic                             is_empty;
    logic                             found;
    logic [fq_pkg::POS_W-1:0]         position;
    logic [fq_pkg::ST_W-1:0]          status;

    modport source (output valid, popped_value, front_value, is_empty, found, position,
                    status, input ready);
    modport sink (input valid, popped_value, front_value, is_empty, found, position,
                  status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fq_cell.sv
// one queue cell: holds an entry, shifts toward the head on pop, compares a key
`default_nettype none
module fq_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fq_pkg::cmd_t   cmd,
    input  wire logic           prev_valid,
    input  wire logic           next_valid,
    input  wire fq_pkg::data_t  next_data,
    output logic                valid,
    output fq_pkg::data_t       data,
    output logic                hit
);
    logic          valid_reg;
    logic          valid_next;
    fq_pkg::data_t data_reg;
    fq_pkg::data_t data_next;
    logic          load;

    // first empty cell behind the last valid one takes the pushed value
    assign load = cmd.push && !valid_reg && prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.pop)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            data_next  = cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign hit   = valid_reg && (data_reg == cmd.data);
endmodule
`default_nettype wire

>>> rtl/core/fq_prio.sv
// priority encoder: 1-based position of the match nearest the head
`default_nettype none
module fq_prio (
    input  wire logic [fq_pkg::DEPTH-1:0] hits,
    output logic                          found,
    output logic [fq_pkg::POS_W-1:0]      position
);
    always_comb
    begin
        position = '0;
        for (int i = fq_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                position = fq_pkg::POS_W'(i + 1);
            end
        end
    end

    assign found = |hits;
endmodule
`default_nettype wire

>>> rtl/core/fifo_queue_with_search.sv
// top level: searchable fifo queue built as a chain of cells
//
//   channel  dir  fields
//   req      in   operation, value
//   rsp      out  popped_value, front_value, is_empty, found, position, status
//
// one request is accepted per cycle while the response is not stalled, and its
// response appears in the output register on the next cycle.
// cell 0 always holds the oldest entry; a pop shifts every cell one place down.
// search compares all cells at once and a priority encoder picks the first hit.
// reset clears the cell valid bits and the response valid bit; the queue is empty.
// a stalled response holds the output register and blocks new requests.
`default_nettype none
module fifo_queue_with_search (
    input  wire logic clk,
    input  wire logic rst_n,
    fq_req_if.sink    req,
    fq_rsp_if.source  rsp
);
    localparam int D = fq_pkg::DEPTH;

    logic                  accept;
    fq_pkg::cmd_t          cmd;
    fq_pkg::data_t         key;
    logic [D-1:0]          cell_valid;
    logic [D-1:0]          nxt_valid;
    logic [D-1:0]          prv_valid;
    logic [D-1:0]          cell_hit;
    logic [D-1:0]          search_hit;
    fq_pkg::data_t         cell_data [D];
    fq_pkg::data_t         nxt_data [D];
    logic                  enc_found;
    logic [fq_pkg::POS_W-1:0] enc_pos;

    logic                             rsp_valid_reg;
    logic signed [fq_pkg::WORD_W-1:0] popped_reg, popped_next;
    logic signed [fq_pkg::WORD_W-1:0] front_reg, front_next;
    logic                             empty_reg, empty_next;
    logic                             found_reg, found_next;
    logic [fq_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [fq_pkg::ST_W-1:0]          status_reg, status_next;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign key       = fq_pkg::DATA_WIDTH'($unsigned(req.value));

    assign cmd.push = accept && (req.operation == fq_pkg::OP_PUSH);
    assign cmd.pop  = accept && (req.operation == fq_pkg::OP_POP) && cell_valid[0];
    assign cmd.data = key;

    assign nxt_valid = {1'b0, cell_valid[D-1:1]};
    assign prv_valid = {cell_valid[D-2:0], 1'b1};

    for (genvar g = 0; g < D; g++)
    begin : g_cell
        if (g == D - 1)
        begin : g_last
            assign nxt_data[g] = '0;
        end
        else
        begin : g_mid
            assign nxt_data[g] = cell_data[g+1];
        end

        fq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_valid (prv_valid[g]),
            .next_valid (nxt_valid[g]),
            .next_data  (nxt_data[g]),
            .valid      (cell_valid[g]),
            .data       (cell_data[g]),
            .hit        (cell_hit[g])
        );
    end

    assign search_hit = (req.operation == fq_pkg::OP_SEARCH) ? cell_hit : '0;

    fq_prio u_prio (
        .hits     (search_hit),
        .found    (enc_found),
        .position (enc_pos)
    );

    // response fields as the queue stands after the operation
    always_comb
    begin
        popped_next = '0;
        status_next = fq_pkg::ST_OK;
        front_next  = cell_valid[0] ? fq_pkg::WORD_W'(cell_data[0]) : '0;
        empty_next  = !cell_valid[0];
        found_next  = enc_found;
        pos_next    = enc_pos;
        case (req.operation)
            fq_pkg::OP_PUSH:
            begin
                empty_next = 1'b0;
                if (cell_valid[D-1])
                begin
                    status_next = fq_pkg::ST_OVERFLOW;
                end
                else if (!cell_valid[0])
                begin
                    front_next = fq_pkg::WORD_W'(key);
                end
            end
            fq_pkg::OP_POP:
            begin
                if (cell_valid[0])
                begin
                    popped_next = fq_pkg::WORD_W'(cell_data[0]);
                    front_next  = cell_valid[1] ? fq_pkg::WORD_W'(cell_data[1]) : '0;
                    empty_next  = !cell_valid[1];
                end
                else
                begin
                    status_next = fq_pkg::ST_UNDERFLOW;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            front_reg  <= front_next;
            empty_reg  <= empty_next;
            found_reg  <= found_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.front_value  = front_reg;
    assign rsp.is_empty     = empty_reg;
    assign rsp.found        = found_reg;
    assign rsp.position     = pos_reg;
    assign rsp.status       = status_reg;

    // valid cells always form a solid run starting at the head
    a_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("cell valid bits are not contiguous from the head");

    // a pop that succeeds removes exactly one entry
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> ($countones(cell_valid) + 1) == $past($countones(cell_valid)))
        else $error("pop did not remove exactly one entry");

    // a refused push leaves every cell untouched
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cell_valid[D-1]) |=> $stable(cell_valid))
        else $error("push on a full queue changed the cells");

    // a reported match always carries a position and is never reported on an empty queue
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && found_reg) |-> (pos_reg != '0 && !empty_reg))
        else $error("match reported without a position or on an empty queue");
endmodule
`default_nettype wire
